### rtl/pfs_pkg.sv
// Shared types, character codes and helpers for the format specifier parser.
package pfs_pkg;

  localparam int NUM_BITS   = 16;
  localparam int COUNT_BITS = 16;

  localparam logic [NUM_BITS-1:0]   NUM_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POUND   = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_LOW_H   = 8'h68;
  localparam logic [7:0] CH_LOW_L   = 8'h6C;
  localparam logic [7:0] CH_UP_L    = 8'h4C;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;

  // Result status codes
  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_END_CLEAN = 2'd2;
  localparam logic [1:0] ST_END_OPEN  = 2'd3;

  // Length modifier codes
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_HH    = 3'd1;
  localparam logic [2:0] LEN_H     = 3'd2;
  localparam logic [2:0] LEN_L     = 3'd3;
  localparam logic [2:0] LEN_LL    = 3'd4;
  localparam logic [2:0] LEN_BIG_L = 3'd5;

  // Flag bit positions
  localparam int FL_PLUS  = 0;
  localparam int FL_MINUS = 1;
  localparam int FL_POUND = 2;
  localparam int FL_ZERO  = 3;
  localparam int FL_SPACE = 4;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_FLAGS = 7'b0000010,
    PH_WIDTH = 7'b0000100,
    PH_PREC  = 7'b0001000,
    PH_LEN_H = 7'b0010000,
    PH_LEN_L = 7'b0100000,
    PH_CONV  = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t                phase;
    logic [4:0]            flags;
    logic [NUM_BITS-1:0]   width_acc;
    logic                  prec_seen;
    logic [NUM_BITS-1:0]   prec_acc;
    logic [2:0]            len_code;
    logic [COUNT_BITS-1:0] total;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  flags;
    logic [15:0] field_width;
    logic        has_precision;
    logic [15:0] precision_value;
    logic [2:0]  length_modifier;
    logic [7:0]  conversion;
    logic [15:0] valid_count;
  } result_t;

  // One decimal digit into a saturating accumulator: acc*10 + digit.
  function automatic logic [NUM_BITS-1:0] acc_digit(input logic [NUM_BITS-1:0] acc,
                                                    input logic [7:0] c);
    logic [NUM_BITS+3:0] wide;
    logic [NUM_BITS+3:0] sum;
    wide = {4'b0, acc};
    sum  = (wide << 3) + (wide << 1) + {{NUM_BITS{1'b0}}, c[3:0]};
    if (sum > {4'b0, NUM_MAX}) begin
      return NUM_MAX;
    end
    return sum[NUM_BITS-1:0];
  endfunction

endpackage

### rtl/pfs_step.sv
// Next-state and result logic for one character of the format text.
module pfs_step
  import pfs_pkg::*;
(
  input  parse_state_t st,
  input  logic [7:0]   character,
  input  logic         end_of_text,
  output parse_state_t nxt,
  output logic         emit,
  output result_t      res
);

  logic       is_digit;
  logic       is_alpha;
  logic [4:0] flag_bit;
  logic       ph_idle, ph_flags, ph_width, ph_prec, ph_len_h, ph_len_l;
  logic       eff_width;
  logic [COUNT_BITS-1:0] total_inc;

  assign is_digit = character inside {[CH_ZERO:CH_NINE]};
  assign is_alpha = character inside {[CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z]};
  assign total_inc = (st.total < COUNT_MAX) ? st.total + 1'b1 : st.total;

  always_comb begin
    case (character)
      CH_PLUS:  flag_bit = 5'b1 << FL_PLUS;
      CH_MINUS: flag_bit = 5'b1 << FL_MINUS;
      CH_POUND: flag_bit = 5'b1 << FL_POUND;
      CH_ZERO:  flag_bit = 5'b1 << FL_ZERO;
      CH_SPACE: flag_bit = 5'b1 << FL_SPACE;
      default:  flag_bit = 5'b0;
    endcase
  end

  always_comb begin
    ph_idle  = 1'b0;
    ph_flags = 1'b0;
    ph_width = 1'b0;
    ph_prec  = 1'b0;
    ph_len_h = 1'b0;
    ph_len_l = 1'b0;
    case (st.phase)
      PH_FLAGS: ph_flags = 1'b1;
      PH_WIDTH: ph_width = 1'b1;
      PH_PREC:  ph_prec  = 1'b1;
      PH_LEN_H: ph_len_h = 1'b1;
      PH_LEN_L: ph_len_l = 1'b1;
      PH_CONV:  ;
      default:  ph_idle  = 1'b1;
    endcase
  end

  // A non-flag character in the flag phase is handled as if in the width phase
  assign eff_width = (ph_flags && flag_bit == 5'b0) || ph_width;

  always_comb begin
    nxt  = st;
    emit = 1'b0;
    res.status          = ST_COMPLETE;
    res.flags           = st.flags;
    res.field_width     = 16'(st.width_acc);
    res.has_precision   = st.prec_seen;
    res.precision_value = 16'(st.prec_acc);
    res.length_modifier = st.len_code;
    res.conversion      = 8'h00;
    res.valid_count     = 16'(st.total);

    if (end_of_text) begin
      emit = 1'b1;
      if (ph_idle) begin
        res.status          = ST_END_CLEAN;
        res.flags           = 5'b0;
        res.field_width     = 16'h0000;
        res.has_precision   = 1'b0;
        res.precision_value = 16'h0000;
        res.length_modifier = LEN_NONE;
      end else begin
        res.status = ST_END_OPEN;
      end
      nxt.phase     = PH_IDLE;
      nxt.flags     = 5'b0;
      nxt.width_acc = '0;
      nxt.prec_seen = 1'b0;
      nxt.prec_acc  = '0;
      nxt.len_code  = LEN_NONE;
      nxt.total     = '0;
    end else if (ph_idle) begin
      nxt.phase = PH_IDLE;
      if (character == CH_PERCENT) begin
        nxt.phase     = PH_FLAGS;
        nxt.flags     = 5'b0;
        nxt.width_acc = '0;
        nxt.prec_seen = 1'b0;
        nxt.prec_acc  = '0;
        nxt.len_code  = LEN_NONE;
      end
    end else if (ph_flags && flag_bit != 5'b0) begin
      nxt.flags = st.flags | flag_bit;
    end else if (eff_width && is_digit) begin
      nxt.width_acc = acc_digit(st.width_acc, character);
      nxt.phase     = PH_WIDTH;
    end else if (eff_width && character == CH_DOT) begin
      nxt.prec_seen = 1'b1;
      nxt.prec_acc  = '0;
      nxt.phase     = PH_PREC;
    end else if (ph_prec && is_digit) begin
      nxt.prec_acc = acc_digit(st.prec_acc, character);
    end else if ((eff_width || ph_prec) && character == CH_LOW_H) begin
      nxt.len_code = LEN_H;
      nxt.phase    = PH_LEN_H;
    end else if ((eff_width || ph_prec) && character == CH_LOW_L) begin
      nxt.len_code = LEN_L;
      nxt.phase    = PH_LEN_L;
    end else if ((eff_width || ph_prec) && character == CH_UP_L) begin
      nxt.len_code = LEN_BIG_L;
      nxt.phase    = PH_CONV;
    end else if (ph_len_h && character == CH_LOW_H) begin
      nxt.len_code = LEN_HH;
      nxt.phase    = PH_CONV;
    end else if (ph_len_l && character == CH_LOW_L) begin
      nxt.len_code = LEN_LL;
      nxt.phase    = PH_CONV;
    end else begin
      // Specifier ends here, complete or malformed; drop the gathered fields
      emit          = 1'b1;
      nxt.flags     = 5'b0;
      nxt.width_acc = '0;
      nxt.prec_seen = 1'b0;
      nxt.prec_acc  = '0;
      nxt.len_code  = LEN_NONE;
      if (is_alpha) begin
        res.status      = ST_COMPLETE;
        res.conversion  = character;
        res.valid_count = 16'(total_inc);
        nxt.total       = total_inc;
        nxt.phase       = PH_IDLE;
      end else begin
        res.status = ST_MALFORMED;
        nxt.phase  = (character == CH_PERCENT) ? PH_FLAGS : PH_IDLE;
      end
    end
  end

endmodule

### rtl/printf_format_spec_parser_top.sv
// Top level of the printf format specifier parser: input stage, state and result register.
// A character is first registered in the input stage; its result is then loaded into the
// result register that drives out_*, and a waiting result can hold it in the input stage.
// Throughput: one character per cycle when not stalled; the only loop is the parse state
// update in pfs_step. The input stage holds one character while a finished result waits,
// so the input keeps moving for characters that produce no result.
// Reset (rst_n low, synchronous): parse state idle, counters zero, both stages empty.
module printf_format_spec_parser_top
  import pfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_character,
  input  logic        in_end_of_text,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_flag_plus,
  output logic        out_flag_minus,
  output logic        out_flag_pound,
  output logic        out_flag_zero,
  output logic        out_flag_space,
  output logic [15:0] out_field_width,
  output logic        out_has_precision,
  output logic [15:0] out_precision_value,
  output logic [2:0]  out_length_modifier,
  output logic [7:0]  out_conversion,
  output logic [15:0] out_valid_count
);

  // Input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_eot_r;

  // Parse state
  parse_state_t state_r, state_nxt;

  // Result register
  logic    out_valid_r, out_valid_nxt;
  result_t res_r;

  // Step logic outputs
  parse_state_t step_nxt;
  logic         step_emit;
  result_t      step_res;

  logic in_take;
  logic s1_fire;
  logic out_take;

  pfs_step u_step (
    .st          (state_r),
    .character   (s1_char_r),
    .end_of_text (s1_eot_r),
    .nxt         (step_nxt),
    .emit        (step_emit),
    .res         (step_res)
  );

  // The staged character advances unless it has a result and the result
  // register is full and stalled.
  assign out_take = out_valid_r && !out_stall;
  assign s1_fire  = s1_valid_r && (!step_emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = s1_fire ? step_nxt : state_r;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && step_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      state_r.phase     <= PH_IDLE;
      state_r.flags     <= 5'b0;
      state_r.width_acc <= '0;
      state_r.prec_seen <= 1'b0;
      state_r.prec_acc  <= '0;
      state_r.len_code  <= LEN_NONE;
      state_r.total     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_character;
      s1_eot_r  <= in_end_of_text;
    end
    if (s1_fire && step_emit) begin
      res_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_flag_plus       = res_r.flags[FL_PLUS];
  assign out_flag_minus      = res_r.flags[FL_MINUS];
  assign out_flag_pound      = res_r.flags[FL_POUND];
  assign out_flag_zero       = res_r.flags[FL_ZERO];
  assign out_flag_space      = res_r.flags[FL_SPACE];
  assign out_field_width     = res_r.field_width;
  assign out_has_precision   = res_r.has_precision;
  assign out_precision_value = res_r.precision_value;
  assign out_length_modifier = res_r.length_modifier;
  assign out_conversion      = res_r.conversion;
  assign out_valid_count     = res_r.valid_count;

  // The end of the text always leaves the running count cleared
  a_eot_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_eot_r |=> state_r.total == '0)
    else $error("count not cleared after end of text");

  // Never overwrite a result that is still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && step_emit |-> !out_valid_r || !out_stall)
    else $error("result register overwritten while stalled");

  // The count only moves by one on a transfer, or is cleared at end of text
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && state_r.total != $past(state_r.total) |->
      $past(s1_fire) && ($past(s1_eot_r) ||
                         state_r.total == COUNT_BITS'($past(state_r.total) + 1'b1)))
    else $error("valid count changed unexpectedly");

endmodule
